### rtl/sdcf_pkg.sv
// Shared constants, types and saturation helper for the contact force block.
package sdcf_pkg;

    localparam int unsigned CfgIdxW   = 2;
    localparam int unsigned StiffW    = 31;
    localparam int unsigned MassW     = 31;
    localparam int unsigned ValW      = 32;
    localparam int unsigned DivSteps  = 31;
    localparam int unsigned SqrtSteps = 31;

    typedef enum logic [CfgIdxW-1:0] {
        REG_STIFFNESS = 2'd0,
        REG_DAMPING   = 2'd1
    } t_cfg_reg;

    localparam logic [StiffW-1:0] StiffReset = 31'd65536;
    localparam logic [StiffW-1:0] DampReset  = 31'd0;

    typedef struct packed {
        logic signed [ValW-1:0] nx;
        logic signed [ValW-1:0] ny;
        logic signed [ValW-1:0] nz;
        logic signed [ValW-1:0] depth;
        logic signed [ValW-1:0] vn;
    } t_side;

    function automatic logic signed [ValW-1:0] sat32(input logic signed [65:0] v);
        logic signed [65:0] lim_hi;
        logic signed [65:0] lim_lo;
        lim_hi = 66'sd2147483647;
        lim_lo = -66'sd2147483648;
        if (v > lim_hi) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (v < lim_lo) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = v[ValW-1:0];
        end
    endfunction

endpackage

### rtl/sdcf_if.sv
// Channel interfaces: contact input, force result and register write.
interface sdcf_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic signed [31:0] rel_vel_x;
    logic signed [31:0] rel_vel_y;
    logic signed [31:0] rel_vel_z;
    logic signed [31:0] pen_depth;
    logic [30:0]        mass_a;
    logic [30:0]        mass_b;
    modport source (output valid, normal_x, normal_y, normal_z, rel_vel_x, rel_vel_y,
                    rel_vel_z, pen_depth, mass_a, mass_b, input ready);
    modport sink   (input valid, normal_x, normal_y, normal_z, rel_vel_x, rel_vel_y,
                    rel_vel_z, pen_depth, mass_a, mass_b, output ready);
endinterface

interface sdcf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic               negative_depth;
    modport source (output valid, force_x, force_y, force_z, negative_depth, input ready);
    modport sink   (input valid, force_x, force_y, force_z, negative_depth, output ready);
endinterface

interface sdcf_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/sdcf_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module sdcf_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [61:0] i_num,
    input  logic [31:0] i_den,
    output logic [30:0] o_quo
);
    import sdcf_pkg::*;

    logic [31:0] r_rem [DivSteps];
    logic [31:0] r_den [DivSteps];
    logic [30:0] r_low [DivSteps];
    logic [30:0] r_quo [DivSteps];
    logic [31:0] n_rem [DivSteps];
    logic [31:0] n_den [DivSteps];
    logic [30:0] n_low [DivSteps];
    logic [30:0] n_quo [DivSteps];

    always_comb begin
        logic [31:0] p_rem;
        logic [30:0] p_low;
        logic [30:0] p_quo;
        logic [32:0] w_try;
        for (int j = 0; j < DivSteps; j++) begin
            p_rem = (j == 0) ? {1'b0, i_num[61:31]} : r_rem[(j == 0) ? 0 : j - 1];
            p_low = (j == 0) ? i_num[30:0] : r_low[(j == 0) ? 0 : j - 1];
            p_quo = (j == 0) ? '0 : r_quo[(j == 0) ? 0 : j - 1];
            n_den[j] = (j == 0) ? i_den : r_den[(j == 0) ? 0 : j - 1];
            w_try = {p_rem, p_low[30]};
            if (w_try >= {1'b0, n_den[j]}) begin
                n_rem[j] = 32'(w_try - {1'b0, n_den[j]});
                n_quo[j] = {p_quo[29:0], 1'b1};
            end else begin
                n_rem[j] = w_try[31:0];
                n_quo[j] = {p_quo[29:0], 1'b0};
            end
            n_low[j] = {p_low[29:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < DivSteps; j++) begin
                r_rem[j] <= n_rem[j];
                r_den[j] <= n_den[j];
                r_low[j] <= n_low[j];
                r_quo[j] <= n_quo[j];
            end
        end
    end

    assign o_quo = (r_den[DivSteps-1] == '0) ? '0 : r_quo[DivSteps-1];

endmodule

### rtl/sdcf_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module sdcf_sqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [61:0] i_val,
    output logic [30:0] o_root
);
    import sdcf_pkg::*;

    logic [32:0] r_rem  [SqrtSteps];
    logic [61:0] r_low  [SqrtSteps];
    logic [30:0] r_root [SqrtSteps];
    logic [32:0] n_rem  [SqrtSteps];
    logic [61:0] n_low  [SqrtSteps];
    logic [30:0] n_root [SqrtSteps];

    always_comb begin
        logic [32:0] p_rem;
        logic [61:0] p_low;
        logic [30:0] p_root;
        logic [34:0] w_cur;
        logic [34:0] w_trial;
        for (int j = 0; j < SqrtSteps; j++) begin
            p_rem  = (j == 0) ? '0 : r_rem[(j == 0) ? 0 : j - 1];
            p_low  = (j == 0) ? i_val : r_low[(j == 0) ? 0 : j - 1];
            p_root = (j == 0) ? '0 : r_root[(j == 0) ? 0 : j - 1];
            w_cur   = {p_rem, p_low[61:60]};
            w_trial = {2'b00, p_root, 2'b01};
            if (w_cur >= w_trial) begin
                n_rem[j]  = 33'(w_cur - w_trial);
                n_root[j] = {p_root[29:0], 1'b1};
            end else begin
                n_rem[j]  = w_cur[32:0];
                n_root[j] = {p_root[29:0], 1'b0};
            end
            n_low[j] = {p_low[59:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < SqrtSteps; j++) begin
                r_rem[j]  <= n_rem[j];
                r_low[j]  <= n_low[j];
                r_root[j] <= n_root[j];
            end
        end
    end

    assign o_root = r_root[SqrtSteps-1];

endmodule

### rtl/spring_dashpot_contact_force.sv
// Top level: pipelined linear spring-dashpot contact force.
//
// Channel   Dir  Carries
// i_item    in   normal, relative velocity, depth, two masses
// o_result  out  force vector, negative depth flag
// i_cfg     in   register index and data (stiffness, damping)
//
// One item per cycle when the result is not stalled; an item passes the 31-stage
// divider and the 31-stage square root in series plus the multiply stages.
// Reset clears the valid bits and loads the register reset values.
// A stall on the result holds every stage; nothing is dropped or repeated.
module spring_dashpot_contact_force (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sdcf_in_if.sink    i_item,
    sdcf_out_if.source o_result,
    sdcf_cfg_if.sink   i_cfg
);
    import sdcf_pkg::*;

    localparam int unsigned Lat     = 70;
    localparam int unsigned SideBeg = 2;
    localparam int unsigned SideEnd = 66;

    logic [StiffW-1:0] r_stiff;
    logic [StiffW-1:0] r_damp;
    logic [Lat:1]      r_v;
    logic              w_adv;

    assign w_adv       = !r_v[Lat] || o_result.ready;
    assign i_item.ready = w_adv;
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stiff <= StiffReset;
            r_damp  <= DampReset;
        end else if (i_cfg.valid) begin
            case (t_cfg_reg'(i_cfg.index))
                REG_STIFFNESS: r_stiff <= i_cfg.data[StiffW-1:0];
                REG_DAMPING:   r_damp  <= i_cfg.data[StiffW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[Lat-1:1], i_item.valid};
        end
    end

    // stage 1: mass product and sum, dot products
    logic [61:0]        r1_pab;
    logic [31:0]        r1_msum;
    logic signed [63:0] r1_dx, r1_dy, r1_dz;
    logic signed [31:0] r1_nx, r1_ny, r1_nz, r1_d;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_pab  <= 62'(i_item.mass_a) * 62'(i_item.mass_b);
            r1_msum <= 32'(i_item.mass_a) + 32'(i_item.mass_b);
            r1_dx   <= 64'(i_item.normal_x) * 64'(i_item.rel_vel_x);
            r1_dy   <= 64'(i_item.normal_y) * 64'(i_item.rel_vel_y);
            r1_dz   <= 64'(i_item.normal_z) * 64'(i_item.rel_vel_z);
            r1_nx   <= i_item.normal_x;
            r1_ny   <= i_item.normal_y;
            r1_nz   <= i_item.normal_z;
            r1_d    <= i_item.pen_depth;
        end
    end

    // stage 2 to 66: side data line
    t_side              r_side [SideBeg:SideEnd];
    logic signed [65:0] w_dsum;

    assign w_dsum = 66'(r1_dx) + 66'(r1_dy) + 66'(r1_dz);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side[SideBeg] <= '{nx: r1_nx, ny: r1_ny, nz: r1_nz, depth: r1_d,
                                 vn: sat32(w_dsum >>> 16)};
            for (int j = SideBeg + 1; j <= SideEnd; j++) begin
                r_side[j] <= r_side[j-1];
            end
        end
    end

    // stages 2 to 32: reduced mass
    logic [30:0] w_ma;

    sdcf_div u_div (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r1_pab),
        .i_den (r1_msum),
        .o_quo (w_ma)
    );

    // stage 33: stiffness times reduced mass
    logic [61:0] r33_km;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r33_km <= 62'(r_stiff) * 62'(w_ma);
        end
    end

    // stages 34 to 64: root
    logic [30:0] w_root;

    sdcf_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_val  (r33_km),
        .o_root (w_root)
    );

    // stages 65 to 70: damping, normal force, force vector
    logic [61:0]        r65_ds;
    logic [30:0]        r66_en;
    logic signed [63:0] r67_kd, r67_ev;
    logic signed [31:0] r67_nx, r67_ny, r67_nz, r68_nx, r68_ny, r68_nz;
    logic               r67_neg, r68_neg, r69_neg;
    logic signed [31:0] r68_fn;
    logic signed [63:0] r69_fx, r69_fy, r69_fz;
    logic signed [31:0] r70_fx, r70_fy, r70_fz;
    logic               r70_neg;
    logic [45:0]        w_ds_sh;
    logic signed [64:0] w_fsum;

    assign w_ds_sh = r65_ds[61:16];
    assign w_fsum  = 65'(r67_kd) + 65'(r67_ev);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r65_ds  <= 62'(r_damp) * 62'(w_root);
            r66_en  <= (w_ds_sh[45:31] != '0) ? '1 : w_ds_sh[30:0];
            r67_kd  <= $signed({33'd0, r_stiff}) * 64'(r_side[SideEnd].depth);
            r67_ev  <= $signed({33'd0, r66_en}) * 64'(r_side[SideEnd].vn);
            r67_nx  <= r_side[SideEnd].nx;
            r67_ny  <= r_side[SideEnd].ny;
            r67_nz  <= r_side[SideEnd].nz;
            r67_neg <= r_side[SideEnd].depth[31];
            r68_fn  <= sat32(66'(w_fsum >>> 16));
            r68_nx  <= r67_nx;
            r68_ny  <= r67_ny;
            r68_nz  <= r67_nz;
            r68_neg <= r67_neg;
            r69_fx  <= 64'(r68_fn) * 64'(r68_nx);
            r69_fy  <= 64'(r68_fn) * 64'(r68_ny);
            r69_fz  <= 64'(r68_fn) * 64'(r68_nz);
            r69_neg <= r68_neg;
            r70_fx  <= sat32(66'(r69_fx >>> 16));
            r70_fy  <= sat32(66'(r69_fy >>> 16));
            r70_fz  <= sat32(66'(r69_fz >>> 16));
            r70_neg <= r69_neg;
        end
    end

    assign o_result.valid          = r_v[Lat];
    assign o_result.force_x        = r70_fx;
    assign o_result.force_y        = r70_fy;
    assign o_result.force_z        = r70_fz;
    assign o_result.negative_depth = r70_neg;

endmodule
